[rtl/rdt_pkg.sv]
// Package with shared types, constants and codes for the record deque table.
`timescale 1ns / 1ps
package rdt_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int KEY_W = 16;
  localparam int AMT_W = 32;
  localparam int TOT_W = 36;
  localparam int PCT_W = 11;
  localparam int CNT_W = 5;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_APPEND = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;
  localparam logic [2:0] ACT_SCALE  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input beat
    logic rd;         // issue memory read at index
    logic cmp;        // compare read key against search key
    logic shift_up;   // move entry at idx-1 to idx
    logic shift_dn;   // move entry at idx+1 to idx
    logic wr_new;     // write the new record at idx
    logic wr_amt;     // write the scaled amount at idx
    logic mul;        // form product
    logic div;        // divide product by 100
    logic idx_clr;    // idx = 0
    logic idx_cnt;    // idx = count
    logic idx_inc;
    logic idx_dec;
    logic fin;        // build result and update count and total
  } rdt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic idx_last;   // idx + 1 >= count
    logic idx_zero;
    logic div_done;
  } rdt_sts_t;
endpackage

[rtl/rdt_if.sv]
// Valid and ready channel interfaces for the table input and result beats.
`timescale 1ns / 1ps
interface rdt_in_if;
  import rdt_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [KEY_W-1:0] item_id;
  logic signed [AMT_W-1:0] amount_in;
  logic signed [PCT_W-1:0] percent;
  modport source (output valid, action, item_id, amount_in, percent, input ready);
  modport sink (input valid, action, item_id, amount_in, percent, output ready);
endinterface

interface rdt_out_if;
  import rdt_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [KEY_W-1:0] item_id_out;
  logic signed [AMT_W-1:0] amount_out;
  logic [CNT_W-1:0] record_count;
  logic signed [TOT_W-1:0] total_amount;
  modport source (output valid, status, item_id_out, amount_out, record_count,
                  total_amount, input ready);
  modport sink (input valid, status, item_id_out, amount_out, record_count,
                total_amount, output ready);
endinterface

[rtl/record_deque_table.sv]
// Top level of the record deque table: ordered records with key lookup.
// Push shifts every record up before writing at the head; append writes at the tail; pop and
// delete shift the later records down; scale multiplies and does a 3-digit divide by 100.
// The table takes one item at a time; the next beat is accepted only after the result is made.
// Reset: synchronous, active high; clears count, total and control, not record storage.
`timescale 1ns / 1ps
module record_deque_table
  import rdt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  rdt_in_if.sink in_ch,
  rdt_out_if.source out_ch
);
  rdt_cmd_t cmd;
  rdt_sts_t sts;
  logic [1:0] res_status;

  rdt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts), .res_status(res_status)
  );

  rdt_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(in_ch.action), .item_id(in_ch.item_id),
    .amount_in(in_ch.amount_in), .percent(in_ch.percent),
    .res_status(res_status),
    .o_status(out_ch.status), .o_id(out_ch.item_id_out), .o_amt(out_ch.amount_out),
    .o_count(out_ch.record_count), .o_total(out_ch.total_amount)
  );
endmodule

[rtl/rdt_datapath.sv]
// Datapath: record memory, index, search, scale arithmetic, count and total.
`timescale 1ns / 1ps
module rdt_datapath
  import rdt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  rdt_cmd_t cmd,
  output rdt_sts_t sts,
  input  logic [2:0] action,
  input  logic [KEY_W-1:0] item_id,
  input  logic signed [AMT_W-1:0] amount_in,
  input  logic signed [PCT_W-1:0] percent,
  input  logic [1:0] res_status,
  output logic [1:0] o_status,
  output logic [KEY_W-1:0] o_id,
  output logic signed [AMT_W-1:0] o_amt,
  output logic [CNT_W-1:0] o_count,
  output logic signed [TOT_W-1:0] o_total
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = AMT_W + PCT_W + 1;
  localparam int QW = PW;
  localparam int DIG_W = 15;
  localparam int DIV_STEPS = 3;
  localparam int MW = DIG_W * DIV_STEPS;
  localparam logic [20:0] RECIP_25 = 21'd1342178;

  logic [KEY_W-1:0] mem_key [DEPTH];
  logic signed [AMT_W-1:0] mem_amt [DEPTH];

  logic [2:0] act;
  logic [KEY_W-1:0] key;
  logic signed [AMT_W-1:0] amt;
  logic signed [PCT_W-1:0] pct;
  logic [CW-1:0] count;
  logic signed [TOT_W-1:0] total;
  logic [CW-1:0] idx;
  logic [KEY_W-1:0] rd_key;
  logic signed [AMT_W-1:0] rd_amt;
  logic [KEY_W-1:0] hit_key;
  logic signed [AMT_W-1:0] hit_amt;
  logic signed [PCT_W:0] fac;
  logic signed [PW-1:0] prod;
  logic [MW-1:0] mag;
  logic [6:0] rem;
  logic [QW-1:0] quo;
  logic neg;
  logic [5:0] dcnt;
  logic [DIG_W+6:0] dv_t;
  logic [DIG_W+4:0] dv_u;
  logic [40:0] dv_p;
  logic [DIG_W-1:0] dv_q;
  logic [DIG_W+6:0] dv_r;
  logic signed [AMT_W-1:0] sat_q;
  logic signed [QW:0] q_s;
  logic [CW-1:0] idx_src;
  logic signed [TOT_W-1:0] delta;
  logic [CW-1:0] count_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      key <= item_id;
      amt <= amount_in;
      pct <= percent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_cnt) begin
      idx <= count;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.idx_dec) begin
      idx <= idx - 1'b1;
    end
  end

  // Shifts read the neighbor via one read port; a later state writes it at idx.
  always_comb begin
    idx_src = idx;
    if (cmd.shift_up) idx_src = idx - 1'b1;
    if (cmd.shift_dn) idx_src = idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= mem_key[idx_src[IW-1:0]];
      rd_amt <= mem_amt[idx_src[IW-1:0]];
    end
    if (cmd.wr_new) begin
      mem_key[idx[IW-1:0]] <= key;
      mem_amt[idx[IW-1:0]] <= amt;
    end else if (cmd.shift_up || cmd.shift_dn) begin
      mem_key[idx[IW-1:0]] <= rd_key;
      mem_amt[idx[IW-1:0]] <= rd_amt;
    end else if (cmd.wr_amt) begin
      mem_amt[idx[IW-1:0]] <= sat_q;
    end
  end

  assign fac = $signed({pct[PCT_W-1], pct}) + (PCT_W+1)'(100);

  // One base 2^15 digit of |product| / 100 per step: the partial dividend stays
  // below 100 * 2^15, so dividing it by 4 and then by 25 with a reciprocal is exact.
  always_comb begin
    dv_t = {rem, mag[MW-1 -: DIG_W]};
    dv_u = dv_t[DIG_W+6:2];
    dv_p = 41'(dv_u) * 41'(RECIP_25);
    dv_q = dv_p[39:25];
    dv_r = dv_t - (DIG_W+7)'(dv_q) * (DIG_W+7)'(7'd100);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= rd_amt * fac;
      dcnt <= '0;
      rem  <= '0;
    end else if (cmd.div) begin
      if (dcnt == 6'd0) begin
        neg <= prod[PW-1];
        mag <= MW'(prod[PW-1] ? -prod : prod);
        quo <= '0;
        rem <= '0;
        dcnt <= 6'd1;
      end else begin
        quo <= {quo[QW-DIG_W-1:0], dv_q};
        mag <= mag << DIG_W;
        rem <= dv_r[6:0];
        dcnt <= dcnt + 1'b1;
      end
    end
  end

  always_comb begin
    q_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (q_s > (QW+1)'(32'sh7fffffff)) sat_q = 32'sh7fffffff;
    else if (q_s < -(QW+1)'(64'sh80000000)) sat_q = 32'sh80000000;
    else sat_q = q_s[AMT_W-1:0];
  end

  always_comb begin
    delta = '0;
    count_next = count;
    if (res_status == ST_OK) begin
      unique case (act)
        ACT_PUSH, ACT_APPEND: begin
          delta = TOT_W'(amt);
          count_next = count + 1'b1;
        end
        ACT_POP, ACT_DELETE: begin
          delta = -TOT_W'(hit_amt);
          count_next = count - 1'b1;
        end
        ACT_SCALE: delta = TOT_W'(sat_q) - TOT_W'(hit_amt);
        default: delta = '0;
      endcase
    end
  end

  // Found record is held in rd_key/rd_amt; shifts overwrite those, so keep a copy.
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_key <= rd_key;
      hit_amt <= rd_amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.fin) begin
      count <= count_next;
      total <= total + delta;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      o_status <= res_status;
      o_count  <= CNT_W'(count_next);
      o_total  <= total + delta;
      if (res_status != ST_OK) begin
        o_id <= '0;
        o_amt <= '0;
      end else if (act == ACT_PUSH || act == ACT_APPEND) begin
        o_id <= key;
        o_amt <= amt;
      end else if (act == ACT_SCALE) begin
        o_id <= hit_key;
        o_amt <= sat_q;
      end else begin
        o_id <= hit_key;
        o_amt <= hit_amt;
      end
    end
  end

  assign sts.full = (count >= CW'(DEPTH));
  assign sts.empty = (count == '0);
  assign sts.hit = (rd_key == key);
  assign sts.idx_last = ((idx + 1'b1) >= count);
  assign sts.idx_zero = (idx == '0);
  assign sts.div_done = (dcnt == 6'(DIV_STEPS + 1));
endmodule

[rtl/rdt_ctrl.sv]
// Controller state machine sequencing search, shift, scale and result beats.
`timescale 1ns / 1ps
module rdt_ctrl
  import rdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] in_action,
  output logic out_valid,
  input  logic out_ready,
  output rdt_cmd_t cmd,
  input  rdt_sts_t sts,
  output logic [1:0] res_status
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_SRD   = 11'b00000000100,
    S_SCMP  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_FIN   = 11'b00001000000,
    S_UPRD  = 11'b00010000000,
    S_UPWR  = 11'b00100000000,
    S_DNRD  = 11'b01000000000,
    S_DNWR  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] act;
  logic [1:0] rs, rs_next;
  logic out_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rs <= ST_OK;
    end else begin
      state <= state_next;
      rs <= rs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) act <= in_action;
  end

  always_ff @(posedge clk) begin
    if (rst) out_pend <= 1'b0;
    else if (cmd.fin) out_pend <= 1'b1;
    else if (out_ready) out_pend <= 1'b0;
  end
  assign out_valid = out_pend;
  assign res_status = rs;

  // New beat may enter while the previous result waits, but it must not finish over it.
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    rs_next = rs;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        rs_next = ST_OK;
        unique case (act)
          ACT_PUSH: begin
            if (sts.full) begin
              rs_next = ST_FULL;
              state_next = S_FIN;
            end else begin
              cmd.idx_cnt = 1'b1;
              state_next = S_UPRD;
            end
          end
          ACT_APPEND: begin
            if (sts.full) rs_next = ST_FULL;
            else cmd.idx_cnt = 1'b1;
            state_next = sts.full ? S_FIN : S_UPWR;
          end
          ACT_POP, ACT_FIND, ACT_DELETE, ACT_SCALE: begin
            if (sts.empty) begin
              rs_next = ST_NONE;
              state_next = S_FIN;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next = S_SRD;
            end
          end
          default: begin
            rs_next = ST_NONE;
            state_next = S_FIN;
          end
        endcase
      end
      S_SRD: begin
        cmd.rd = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (act == ACT_POP || sts.hit) begin
          cmd.cmp = 1'b1;
          if (act == ACT_SCALE) state_next = S_MUL;
          else if (act == ACT_FIND) state_next = S_FIN;
          else state_next = S_DNRD;
        end else if (sts.idx_last) begin
          rs_next = ST_NONE;
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_SRD;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wr_amt = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.div = 1'b1;
        end
      end
      // Head insert: walk idx down from count, copying idx-1 into idx.
      S_UPRD: begin
        if (sts.idx_zero) begin
          state_next = S_UPWR;
        end else begin
          cmd.shift_up = 1'b1;
          cmd.rd = 1'b1;
          state_next = S_UPWR;
          rs_next = ST_OK;
        end
      end
      S_UPWR: begin
        if (act == ACT_PUSH && !sts.idx_zero) begin
          cmd.shift_up = 1'b1;
          cmd.idx_dec = 1'b1;
          state_next = S_UPRD;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_FIN;
        end
      end
      // Removal: walk idx up, copying idx+1 into idx until the last entry.
      S_DNRD: begin
        if (sts.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.shift_dn = 1'b1;
          cmd.rd = 1'b1;
          state_next = S_DNWR;
        end
      end
      S_DNWR: begin
        cmd.shift_dn = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_DNRD;
      end
      S_FIN: begin
        if (!out_pend || out_ready) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_pend || out_ready))
    else $error("result beat overwritten");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DEC)
    else $error("accepted beat not decoded");
  a_no_both_shift: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift_up && cmd.shift_dn))
    else $error("conflicting shifts");
`endif
endmodule

[tb/tb_checker.sv]
// Checker that predicts each result beat of the record table and compares it.
`timescale 1ns / 1ps
module tb_checker
  import rdt_pkg::*;
(
  input logic clk,
  input logic rst,
  rdt_in_if in_ch,
  rdt_out_if out_ch,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic [1:0] status;
    logic [KEY_W-1:0] id;
    logic signed [AMT_W-1:0] amt;
    logic [CNT_W-1:0] cnt;
    logic signed [TOT_W-1:0] tot;
  } table_result_t;

  logic [KEY_W-1:0] shadow_keys[DEPTH_DEF];
  logic signed [AMT_W-1:0] shadow_amts[DEPTH_DEF];
  int shadow_count;
  logic signed [TOT_W-1:0] shadow_total;
  table_result_t result_queue[$];

  assign pending = result_queue.size();

  function automatic int lookup_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_keys[i] = shadow_keys[i+1];
      shadow_amts[i] = shadow_amts[i+1];
    end
    shadow_count--;
  endfunction

  function automatic table_result_t apply_action(logic [2:0] act, logic [KEY_W-1:0] key,
                                                  logic signed [AMT_W-1:0] amt,
                                                  logic signed [PCT_W-1:0] pct);
    table_result_t r;
    int pos;
    longint q;
    r = '0;
    case (act)
      ACT_PUSH, ACT_APPEND: begin
        if (shadow_count >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          if (act == ACT_PUSH) begin
            for (int i = shadow_count; i > 0; i--) begin
              shadow_keys[i] = shadow_keys[i-1];
              shadow_amts[i] = shadow_amts[i-1];
            end
            pos = 0;
          end else begin
            pos = shadow_count;
          end
          shadow_keys[pos] = key;
          shadow_amts[pos] = amt;
          shadow_count++;
          shadow_total = shadow_total + TOT_W'(amt);
          r.id = key;
          r.amt = amt;
        end
      end
      ACT_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_NONE;
        end else begin
          r.id = shadow_keys[0];
          r.amt = shadow_amts[0];
          shadow_total = shadow_total - TOT_W'(shadow_amts[0]);
          drop_entry(0);
        end
      end
      ACT_FIND, ACT_DELETE, ACT_SCALE: begin
        pos = lookup_key(key);
        if (pos < 0) begin
          r.status = ST_NONE;
        end else begin
          r.id = shadow_keys[pos];
          r.amt = shadow_amts[pos];
          if (act == ACT_DELETE) begin
            shadow_total = shadow_total - TOT_W'(shadow_amts[pos]);
            drop_entry(pos);
          end else if (act == ACT_SCALE) begin
            // SystemVerilog division truncates toward zero, as required.
            q = (longint'(shadow_amts[pos]) * (100 + longint'(pct))) / 100;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            shadow_total = shadow_total + TOT_W'(q - longint'(shadow_amts[pos]));
            shadow_amts[pos] = AMT_W'(q);
            r.amt = AMT_W'(q);
          end
        end
      end
      default: r.status = ST_NONE;
    endcase
    r.cnt = CNT_W'(shadow_count);
    r.tot = shadow_total;
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst) begin
      shadow_count <= 0;
      shadow_total <= '0;
      fail_count <= 0;
      result_queue.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        result_queue.push_back(apply_action(in_ch.action, in_ch.item_id, in_ch.amount_in,
                                            in_ch.percent));
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (exp_r.status !== out_ch.status ||
              exp_r.id !== out_ch.item_id_out ||
              exp_r.amt !== out_ch.amount_out ||
              exp_r.cnt !== out_ch.record_count ||
              exp_r.tot !== out_ch.total_amount)
            fail_count <= fail_count + 1;
          if (exp_r.status !== out_ch.status)
            $error("status expected %0d got %0d", exp_r.status, out_ch.status);
          if (exp_r.id !== out_ch.item_id_out)
            $error("item_id_out expected %0d got %0d", exp_r.id, out_ch.item_id_out);
          if (exp_r.amt !== out_ch.amount_out)
            $error("amount_out expected %0d got %0d", exp_r.amt, out_ch.amount_out);
          if (exp_r.cnt !== out_ch.record_count)
            $error("record_count expected %0d got %0d", exp_r.cnt, out_ch.record_count);
          if (exp_r.tot !== out_ch.total_amount)
            $error("total_amount expected %0d got %0d", exp_r.tot, out_ch.total_amount);
        end
      end
    end
  end
endmodule

[tb/tb.sv]
// Testbench top: drives action beats into the record table and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import rdt_pkg::*;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  longint cycle_count = 0;
  logic [KEY_W-1:0] used_keys[$];

  rdt_in_if in_ch();
  rdt_out_if out_ch();

  record_deque_table u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  tb_checker u_checker (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                        .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("record_deque_table verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // One beat: random idle gap, then hold valid until accepted.
  task automatic send_beat(logic [2:0] act, logic [KEY_W-1:0] key,
                           logic signed [AMT_W-1:0] amt, logic signed [PCT_W-1:0] pct);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.item_id <= key;
    in_ch.amount_in <= amt;
    in_ch.percent <= pct;
    do @(posedge clk); while (!in_ch.ready);
    if (act == ACT_PUSH || act == ACT_APPEND) used_keys.push_back(key);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(9) < 8)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if ($urandom_range(3) == 0) return KEY_W'($urandom_range(7));
    return KEY_W'($urandom);
  endfunction

  function automatic logic signed [AMT_W-1:0] pick_amount();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return AMT_W'($urandom_range(2000)) - 1000;
      default: return AMT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [PCT_W-1:0] pick_percent();
    case ($urandom_range(4))
      0: return 11'sd1000;
      1: return -11'sd1000;
      2: return -11'sd100;
      default: return PCT_W'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic random_beats(int n);
    logic [2:0] act;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 22) act = ACT_PUSH;
      else if (r < 44) act = ACT_APPEND;
      else if (r < 56) act = ACT_POP;
      else if (r < 68) act = ACT_FIND;
      else if (r < 80) act = ACT_DELETE;
      else if (r < 97) act = ACT_SCALE;
      else act = 3'($urandom_range(7, 6));
      send_beat(act, pick_key(), pick_amount(), pick_percent());
    end
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_FIND;
    in_ch.item_id = '0;
    in_ch.amount_in = '0;
    in_ch.percent = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop and miss, field extremes, fill to full, odd codes.
    send_beat(ACT_POP, 16'h0, 0, 0);
    send_beat(ACT_FIND, 16'hffff, 0, 0);
    send_beat(ACT_PUSH, 16'hffff, 32'sh7fffffff, 11'sd1000);
    send_beat(ACT_APPEND, 16'h0000, 32'sh80000000, -11'sd1000);
    send_beat(ACT_SCALE, 16'hffff, 0, 11'sd1000);
    send_beat(ACT_SCALE, 16'h0000, 0, 11'sd1000);
    send_beat(ACT_SCALE, 16'h0000, 0, -11'sd1000);
    send_beat(ACT_SCALE, 16'hffff, 0, -11'sd150);
    send_beat(ACT_APPEND, 16'h5555, -32'sd199, 0);
    send_beat(ACT_SCALE, 16'h5555, 0, -11'sd1);
    for (int i = 0; i < 14; i++) send_beat(ACT_APPEND, 16'h00aa, 32'sh7fffffff, 0);
    send_beat(ACT_PUSH, 16'h1234, 1, 0);
    send_beat(ACT_DELETE, 16'h5555, 0, 0);
    send_beat(3'd6, 16'h1, 1, 1);
    send_beat(3'd7, 16'h2, 2, 2);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 64; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 64; end
        3: begin idle_pct = 36; stall_pct = 36; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      random_beats(185);
    end
    in_ch.valid <= 1'b0;
    idle_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("record_deque_table verification clean");
    else $display("record_deque_table verification failed");
    $finish;
  end
endmodule

[sim.f]
rtl/rdt_pkg.sv
rtl/rdt_if.sv
rtl/rdt_datapath.sv
rtl/rdt_ctrl.sv
rtl/record_deque_table.sv
tb/tb_checker.sv
tb/tb.sv
